[hdl/fcm_pkg.sv]
// shared types and constants of the felics context modeler
`default_nettype none

package fcm_pkg;

  localparam int LINE_WIDTH = 256;
  localparam int NUM_K      = 8;
  localparam int NUM_ROWS   = 256;

  localparam int COL_W  = $clog2(LINE_WIDTH);
  localparam int ROW_W  = $clog2(NUM_ROWS);
  localparam int K_W    = $clog2(NUM_K);
  localparam int NUM_KP = 1 << K_W;
  localparam int PIX_W  = 8;
  localparam int SUM_W  = 25;
  localparam int SIZE_W = 9;
  localparam int RICE_W = 3;

  localparam logic [SUM_W-1:0]  SUM_MAX       = {SUM_W{1'b1}};
  localparam logic [RICE_W-1:0] FIXED_K_RESET = 3'd2;

  typedef enum logic [1:0] {
    TOK_RAW   = 2'd0,
    TOK_IN    = 2'd1,
    TOK_BELOW = 2'd2,
    TOK_ABOVE = 2'd3
  } tok_kind_e;

  typedef enum logic [0:0] {
    CFG_USE_FIXED_K = 1'b0,
    CFG_FIXED_K     = 1'b1
  } cfg_idx_e;

  // update request to the cost bank
  typedef struct packed {
    logic             upd;
    logic             clr;
    logic [PIX_W-1:0] distance;
  } cost_cmd_t;

  // pixel context held between the line store read and the token stage
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic             col_zero;
    logic             col_one;
    logic             first_row;
    logic             last;
  } pix_ctx_t;

endpackage

`default_nettype wire

[hdl/fcm_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none

module fcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/fcm_cost_bank.sv]
// running rice cost sums with argmin selection
`default_nettype none

module fcm_cost_bank
  import fcm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cost_cmd_t cmd_i,
  output logic [K_W-1:0] best_k_o
);

  logic [SUM_W-1:0] sums_q [NUM_K];
  logic [SUM_W-1:0] sums_d [NUM_K];
  logic [SUM_W-1:0] node_v [2*NUM_KP-1];
  logic [K_W-1:0]   node_i [2*NUM_KP-1];

  // comparison tree, the right child wins only when strictly smaller
  always_comb begin
    for (int i = 0; i < NUM_KP; i++) begin
      node_v[NUM_KP-1+i] = (i < NUM_K) ? sums_q[i] : SUM_MAX;
      node_i[NUM_KP-1+i] = K_W'(i);
    end
    for (int n = NUM_KP - 2; n >= 0; n--) begin
      if (node_v[2*n+2] < node_v[2*n+1]) begin
        node_v[n] = node_v[2*n+2];
        node_i[n] = node_i[2*n+2];
      end else begin
        node_v[n] = node_v[2*n+1];
        node_i[n] = node_i[2*n+1];
      end
    end
  end

  assign best_k_o = node_i[0];

  // lane i adds (d >> i) + 1 + i, saturating
  always_comb begin
    logic [SUM_W:0] lane;
    for (int i = 0; i < NUM_K; i++) begin
      lane = {1'b0, sums_q[i]} + (SUM_W+1)'(cmd_i.distance >> i) + (SUM_W+1)'(i + 1);
      sums_d[i] = sums_q[i];
      if (cmd_i.upd) begin
        sums_d[i] = lane[SUM_W] ? SUM_MAX : lane[SUM_W-1:0];
      end
      if (cmd_i.clr) begin
        sums_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_K; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_K; i++) begin
        sums_q[i] <= sums_d[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr |=> sums_q[0] == '0 && sums_q[NUM_K-1] == '0)
    else $error("cost sums not cleared at image end");

  a_update_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && !cmd_i.clr |=> sums_q[NUM_K-1] != '0)
    else $error("cost sum did not grow on update");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.upd && !cmd_i.clr |=> $stable(best_k_o))
    else $error("best k changed without an update");
`endif

endmodule

`default_nettype wire

[hdl/felics_context_modeler.sv]
// felics context modeler top level: line store, token stage and output register
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] pixel
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata code, size, k; tuser kind; tlast end
//   cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// one pixel per clock sustained while the output is not stalled; a token passes from its pixel
// transfer through the line store read and the token compute into the output register
// the cost update and eight-way minimum close in the token stage, so k always sees
// the sums left by the token before
// reset clears counters, cost sums and pipeline valids; the line store needs no clear
// a stalled output register holds the token stage, and the input stalls with it
`default_nettype none

module felics_context_modeler
  import fcm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // pixel input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
  // token output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] code_value, [16:8] range_size,
                                           // [19:17] rice_k, [23:20] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] token_kind
  output logic             m_axis_tlast,   // image_end
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [2:0]  cfg_data_i
);

  // configuration
  logic              use_fixed_q;
  logic [RICE_W-1:0] fixed_k_q;
  logic              cfg_write;

  // position counters
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             col_wrap;
  logic             in_last;

  // pipeline control
  logic     s_accept;
  logic     s1_free;
  logic     s1_move;
  logic     out_en;
  logic     s1_valid_q;
  pix_ctx_t s1_q;

  // neighbor registers of the current and previous row
  logic [PIX_W-1:0] left1_q, left2_q, right1_q;
  logic [PIX_W-1:0] above;

  // token stage
  logic [PIX_W-1:0]  n1, n2, hi, lo, code, distance;
  logic [SIZE_W-1:0] size;
  logic [RICE_W-1:0] k_sel;
  logic [K_W+RICE_W-1:0] best_wide;
  logic [K_W-1:0]    best_k;
  logic              raw;
  tok_kind_e         kind;
  cost_cmd_t         cost_cmd;

  // output register
  logic              out_valid_q;
  tok_kind_e         out_kind_q;
  logic [PIX_W-1:0]  out_code_q;
  logic [SIZE_W-1:0] out_size_q;
  logic [RICE_W-1:0] out_k_q;
  logic              out_last_q;

  // ---------------------------------------------------------------------------
  // configuration registers, always ready

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_fixed_q <= 1'b0;
      fixed_k_q   <= FIXED_K_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_USE_FIXED_K: use_fixed_q <= cfg_data_i[0];
        CFG_FIXED_K:     fixed_k_q   <= cfg_data_i;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the token stage moves when the output register is free or drains

  assign out_en        = !out_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && out_en;
  assign s1_free       = !s1_valid_q || out_en;
  assign s_axis_tready = s1_free;
  assign s_accept      = s_axis_tvalid && s1_free;

  // ---------------------------------------------------------------------------
  // raster position, advanced on each input transfer

  assign col_wrap = (col_q == COL_W'(LINE_WIDTH - 1));
  assign in_last  = col_wrap && (row_q == ROW_W'(NUM_ROWS - 1));

  always_comb begin
    col_d = col_q + COL_W'(1);
    row_d = row_q;
    if (col_wrap) begin
      col_d = '0;
      row_d = in_last ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (s_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // line store: read the pixel above at transfer, write the pixel in the token stage

  fcm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (LINE_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_move),
    .waddr_i (s1_q.col),
    .wdata_i (s1_q.pixel),
    .re_i    (s_accept),
    .raddr_i (col_q),
    .rdata_o (above)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= s_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_q.pixel     <= s_axis_tdata;
      s1_q.col       <= col_q;
      s1_q.col_zero  <= (col_q == '0);
      s1_q.col_one   <= (col_q == COL_W'(1));
      s1_q.first_row <= (row_q == '0);
      s1_q.last      <= in_last;
    end
  end

  // left pixels of this row and column one of the row before
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      left1_q <= s1_q.pixel;
      left2_q <= left1_q;
      if (s1_q.col_one) begin
        right1_q <= s1_q.pixel;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // neighbor selection per edge rules

  always_comb begin
    n1  = left1_q;
    n2  = left1_q;
    raw = 1'b0;
    if (!s1_q.first_row) begin
      if (s1_q.col_zero) begin
        // above and above-right
        n1 = above;
        n2 = right1_q;
      end else begin
        n2 = above;
      end
    end else if (s1_q.col_zero) begin
      raw = 1'b1;
    end else if (!s1_q.col_one) begin
      n2 = left2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // classification against [lo, hi]

  assign hi = (n1 > n2) ? n1 : n2;
  assign lo = (n1 > n2) ? n2 : n1;

  always_comb begin
    kind     = TOK_RAW;
    code     = s1_q.pixel;
    size     = '0;
    distance = '0;
    if (!raw) begin
      if (s1_q.pixel < lo) begin
        kind     = TOK_BELOW;
        distance = lo - s1_q.pixel - PIX_W'(1);
        code     = distance;
      end else if (s1_q.pixel > hi) begin
        kind     = TOK_ABOVE;
        distance = s1_q.pixel - hi - PIX_W'(1);
        code     = distance;
      end else begin
        kind = TOK_IN;
        code = s1_q.pixel - lo;
        size = SIZE_W'(hi) - SIZE_W'(lo) + SIZE_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // cost sums: update on out-of-range tokens, clear after the last pixel

  assign cost_cmd.upd      = s1_move && (kind == TOK_BELOW || kind == TOK_ABOVE);
  assign cost_cmd.clr      = s1_move && s1_q.last;
  assign cost_cmd.distance = distance;

  fcm_cost_bank u_cost_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cost_cmd),
    .best_k_o (best_k)
  );

  // widen then keep the low rice bits, whatever the index width
  assign best_wide = {{RICE_W{1'b0}}, best_k};
  assign k_sel     = use_fixed_q ? fixed_k_q : best_wide[RICE_W-1:0];

  // ---------------------------------------------------------------------------
  // output register

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_kind_q <= kind;
      out_code_q <= code;
      out_size_q <= size;
      out_k_q    <= (kind == TOK_BELOW || kind == TOK_ABOVE) ? k_sel : '0;
      out_last_q <= s1_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_k_q, out_size_q, out_code_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_en |=> s1_valid_q && $stable(s1_q.pixel))
    else $error("token stage lost its pixel while stalled");

  a_in_range_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == TOK_IN |-> out_size_q != '0 &&
      SIZE_W'(out_code_q) < out_size_q)
    else $error("in-range offset outside range size");

  a_image_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && in_last |=> col_q == '0 && row_q == '0)
    else $error("raster position did not wrap at image end");
`endif

endmodule

`default_nettype wire
